@@ rtl/core/pss_pkg.sv @@
// shared types, constants and the quarter-wave sine table for the sine synth
// no dependencies
package pss_pkg;

    localparam int NUM_VOICES = 8;
    localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W      = $clog2(NUM_VOICES + 1);

    localparam int MODE_W     = 2;
    localparam int FREQ_W     = 23;
    localparam int RATE_W     = 18;
    localparam int ENV_W      = 16;
    localparam int SAMPLE_W   = 20;
    localparam int TERM_W     = 20;
    localparam int ACC_W      = SAMPLE_W + IDX_W + 2;
    localparam int STEP_FRAC  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_MULT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_MULT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_LEVEL  = 3'd4;

    localparam logic [ENV_W-1:0] ENV_ONE = 16'hFFFF;

    typedef struct packed {
        logic [31:0]      phase;
        logic [31:0]      step;
        logic             active;
        logic [ENV_W-1:0] attack;
        logic [ENV_W-1:0] decay;
    } voice_t;

    localparam int VOICE_W = $bits(voice_t);

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [ENV_W-1:0]  amplitude;
        logic [ENV_W-1:0]  att_mult;
        logic [ENV_W-1:0]  dec_mult;
        logic [ENV_W-1:0]  mute_level;
    } cfg_t;

    typedef struct packed {
        logic load_entry;
        logic scale;
        logic mult;
    } stage_t;

    function automatic logic [15:0] sine_point(input logic [5:0] idx);
        logic [15:0] v;
        case (idx)
            6'd0:  v = 16'd0;
            6'd1:  v = 16'd1608;
            6'd2:  v = 16'd3212;
            6'd3:  v = 16'd4808;
            6'd4:  v = 16'd6393;
            6'd5:  v = 16'd7962;
            6'd6:  v = 16'd9512;
            6'd7:  v = 16'd11039;
            6'd8:  v = 16'd12539;
            6'd9:  v = 16'd14010;
            6'd10: v = 16'd15446;
            6'd11: v = 16'd16846;
            6'd12: v = 16'd18204;
            6'd13: v = 16'd19519;
            6'd14: v = 16'd20787;
            6'd15: v = 16'd22005;
            6'd16: v = 16'd23170;
            6'd17: v = 16'd24279;
            6'd18: v = 16'd25329;
            6'd19: v = 16'd26319;
            6'd20: v = 16'd27245;
            6'd21: v = 16'd28105;
            6'd22: v = 16'd28898;
            6'd23: v = 16'd29621;
            6'd24: v = 16'd30273;
            6'd25: v = 16'd30852;
            6'd26: v = 16'd31356;
            6'd27: v = 16'd31785;
            6'd28: v = 16'd32137;
            6'd29: v = 16'd32412;
            6'd30: v = 16'd32609;
            6'd31: v = 16'd32728;
            6'd32: v = 16'd32767;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/poly_sine_synth_envelope.sv @@
// top level of the polyphonic sine synth: sequencer, voice ring buffer in ram
// depends on pss_pkg, pss_ram, pss_div, pss_voice
//
//  channel  | direction | transfer on            | payload
//  s_*      | in        | s_tvalid && s_tready   | tuser: mode, tdata: frequency
//  m_*      | out       | m_tvalid && m_tready   | tdata: sample
//  cfg_*    | in        | cfg_wr_en              | cfg_index, cfg_data
//
// tick: per listed voice, one ram read, three multiply stages and an accumulate
// add: waits until the bit-serial step divider is done; remove: handled while idle
// voices live in a ring in one ram; reset needs no clearing pass
// a finished sample waits in the output register; a tick holds only while it is full
module poly_sine_synth_envelope (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pss_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
    input  logic [23:0]                    s_tdata,   // [22:0] frequency
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [19:0] sample
    input  logic                           cfg_wr_en,
    input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pss_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DIV   = 8'b00000010,
        S_RD    = 8'b00000100,
        S_ENV   = 8'b00001000,
        S_SCALE = 8'b00010000,
        S_TERM  = 8'b00100000,
        S_ACC   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t             state_reg;
    cfg_t               cfg_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   n_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;

    logic               in_xfer;
    logic [IDX_W-1:0]   cur_slot;
    logic [IDX_W-1:0]   tail_slot;
    logic [IDX_W-1:0]   head_inc;
    logic               out_free;
    logic               last_voice;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    voice_t             ram_wdata;
    voice_t             ram_rdata;
    voice_t             wb_entry;
    voice_t             new_entry;

    logic               div_done;
    logic [31:0]        div_q;
    stage_t             stage;
    logic               v_active;
    logic               v_neg;
    logic [TERM_W-1:0]  v_term;
    logic signed [ACC_W-1:0] term_ext;
    logic signed [ACC_W-1:0] sat_hi;
    logic signed [ACC_W-1:0] sat_lo;
    logic [SAMPLE_W-1:0] sat_val;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(NUM_VOICES))
        begin
            s = s - (IDX_W+1)'(NUM_VOICES);
        end
        return s[IDX_W-1:0];
    endfunction

    assign s_tready   = (state_reg == S_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign cur_slot   = ring_add(head_reg, n_reg);
    assign tail_slot  = ring_add(head_reg, IDX_W'(count_reg));
    assign head_inc   = (head_reg == IDX_W'(NUM_VOICES - 1)) ? '0 : head_reg + 1'b1;
    assign out_free   = !m_valid_reg || m_tready;
    assign last_voice = (CNT_W'(n_reg) + 1'b1) == count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate <= 18'd48000;
            cfg_reg.amplitude   <= 16'd32767;
            cfg_reg.att_mult    <= 16'd65000;
            cfg_reg.dec_mult    <= 16'd65530;
            cfg_reg.mute_level  <= 16'd66;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SAMPLE_RATE: cfg_reg.sample_rate <= cfg_data;
                REG_AMPLITUDE:   cfg_reg.amplitude   <= cfg_data[ENV_W-1:0];
                REG_ATT_MULT:    cfg_reg.att_mult    <= cfg_data[ENV_W-1:0];
                REG_DEC_MULT:    cfg_reg.dec_mult    <= cfg_data[ENV_W-1:0];
                REG_MUTE_LEVEL:  cfg_reg.mute_level  <= cfg_data[ENV_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            n_reg       <= '0;
            slot_reg    <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (s_tuser)
                            MODE_TICK:
                            begin
                                acc_reg   <= '0;
                                n_reg     <= '0;
                                state_reg <= (count_reg == '0) ? S_DONE : S_RD;
                            end
                            MODE_ADD:
                            begin
                                if (count_reg == CNT_W'(NUM_VOICES))
                                begin
                                    // full list: oldest slot becomes the newest
                                    slot_reg <= head_reg;
                                    head_reg <= head_inc;
                                end
                                else
                                begin
                                    slot_reg  <= tail_slot;
                                    count_reg <= count_reg + 1'b1;
                                end
                                state_reg <= S_DIV;
                            end
                            MODE_REMOVE:
                            begin
                                head_reg <= head_inc;
                                if (count_reg != '0)
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:    state_reg <= S_ENV;
                S_ENV:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_TERM;
                S_TERM:  state_reg <= S_ACC;
                S_ACC:
                begin
                    if (v_active)
                    begin
                        acc_reg <= v_neg ? acc_reg - term_ext : acc_reg + term_ext;
                    end
                    if (last_voice)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign term_ext = ACC_W'(v_term);
    assign sat_hi   = ACC_W'(524287);
    assign sat_lo   = -ACC_W'(524288);

    always_comb
    begin
        if (acc_reg > sat_hi)
        begin
            sat_val = sat_hi[SAMPLE_W-1:0];
        end
        else if (acc_reg < sat_lo)
        begin
            sat_val = sat_lo[SAMPLE_W-1:0];
        end
        else
        begin
            sat_val = acc_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            m_data_reg <= sat_val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

    // new voice entry once the step is ready
    always_comb
    begin
        new_entry.phase  = '0;
        new_entry.step   = (cfg_reg.sample_rate == '0) ? '0 : div_q;
        new_entry.active = 1'b1;
        new_entry.attack = ENV_ONE;
        new_entry.decay  = ENV_ONE;
    end

    // inactive voices keep their stored state
    assign ram_we    = (state_reg == S_DIV && div_done) || (state_reg == S_SCALE && v_active);
    assign ram_waddr = (state_reg == S_DIV) ? slot_reg : cur_slot;
    assign ram_wdata = (state_reg == S_DIV) ? new_entry : wb_entry;

    assign stage.load_entry = (state_reg == S_ENV);
    assign stage.scale      = (state_reg == S_SCALE);
    assign stage.mult       = (state_reg == S_TERM);

    pss_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (NUM_VOICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == S_RD),
        .raddr (cur_slot),
        .rdata (ram_rdata)
    );

    pss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer && s_tuser == MODE_ADD),
        .dividend (s_tdata[FREQ_W-1:0]),
        .divisor  (cfg_reg.sample_rate),
        .done     (div_done),
        .quotient (div_q)
    );

    pss_voice u_voice (
        .clk      (clk),
        .stage    (stage),
        .entry    (ram_rdata),
        .cfg      (cfg_reg),
        .wb_entry (wb_entry),
        .active   (v_active),
        .neg      (v_neg),
        .term     (v_term)
    );

endmodule

@@ rtl/core/pss_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/pss_div.sv @@
// bit-serial restoring divider for the phase step: (frequency << 24) / sample_rate
// depends on pss_pkg
module pss_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pss_pkg::FREQ_W-1:0] dividend,
    input  logic [pss_pkg::RATE_W-1:0] divisor,
    output logic                       done,
    output logic [31:0]                quotient
);
    import pss_pkg::*;

    localparam int DVD_W = FREQ_W + STEP_FRAC;
    localparam int CNT_W_DIV = $clog2(DVD_W);

    logic [DVD_W-1:0]     dvd_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    dsr_reg;
    logic [31:0]          q_reg;
    logic [CNT_W_DIV-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W_DIV'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {dividend, {STEP_FRAC{1'b0}}};
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/core/pss_voice.sv @@
// per-voice datapath: envelope products, sine lookup and state update
// depends on pss_pkg
module pss_voice (
    input  logic                         clk,
    input  pss_pkg::stage_t              stage,
    input  pss_pkg::voice_t              entry,
    input  pss_pkg::cfg_t                cfg,
    output pss_pkg::voice_t              wb_entry,
    output logic                         active,
    output logic                         neg,
    output logic [pss_pkg::TERM_W-1:0]   term
);
    import pss_pkg::*;

    logic [31:0]      env_prod;
    logic [31:0]      att_prod;
    logic [31:0]      dec_prod;
    logic [6:0]       top;
    logic [5:0]       idx;

    logic [ENV_W-1:0] env1_reg;
    logic [ENV_W-1:0] env2_reg;
    logic [ENV_W-1:0] att_reg;
    logic [ENV_W-1:0] dec_reg;
    logic [31:0]      phase_reg;
    logic [31:0]      step_reg;
    logic [15:0]      mag_reg;
    logic             neg_reg;
    logic             active_reg;
    logic [TERM_W-1:0] term_reg;
    logic [31:0]      scale_prod;
    logic [31:0]      term_prod;

    assign env_prod = (ENV_ONE - entry.attack) * entry.decay;
    assign att_prod = entry.attack * cfg.att_mult;
    assign dec_prod = entry.decay * cfg.dec_mult;
    assign top      = entry.phase[31:25];
    // odd quadrants run the table backwards
    assign idx      = top[5] ? (6'd32 - {1'b0, top[4:0]}) : {1'b0, top[4:0]};

    assign scale_prod = cfg.amplitude * env1_reg;
    assign term_prod  = mag_reg * env2_reg;

    always_ff @(posedge clk)
    begin
        if (stage.load_entry)
        begin
            env1_reg   <= env_prod[31:16];
            att_reg    <= att_prod[31:16];
            dec_reg    <= dec_prod[31:16];
            phase_reg  <= entry.phase + entry.step;
            step_reg   <= entry.step;
            mag_reg    <= sine_point(idx);
            neg_reg    <= top[6];
            active_reg <= entry.active;
        end
        if (stage.scale)
        begin
            env2_reg <= scale_prod[31:16];
        end
        if (stage.mult)
        begin
            term_reg <= term_prod[31:12];
        end
    end

    always_comb
    begin
        wb_entry.phase  = phase_reg;
        wb_entry.step   = step_reg;
        wb_entry.attack = att_reg;
        wb_entry.decay  = dec_reg;
        wb_entry.active = !(dec_reg < cfg.mute_level);
    end

    assign active = active_reg;
    assign neg    = neg_reg;
    assign term   = term_reg;

endmodule

@@ rtl/core/pss_checker.sv @@
// port-level checks for the sine synth top level, attached by bind
// depends on pss_pkg and poly_sine_synth_envelope
module pss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [pss_pkg::MODE_W-1:0] s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [23:0]                m_tdata
);
    import pss_pkg::*;

    // stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // tick and add keep the block busy after their transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == MODE_TICK || s_tuser == MODE_ADD)
        |=> !s_tready)
        else $error("input ready right after tick or add");

    // a sample only appears at the end of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("sample appeared while idle");

    // padding above the sample stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:20] == 4'b0000)
        else $error("sample padding not zero");

endmodule

bind poly_sine_synth_envelope pss_checker u_pss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
